// ===== rtl/core/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, register indexes and helpers of the button power sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;

  typedef logic [CountWidth-1:0] count_t;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_ON_PRESS      = 2'd0,
    REG_ON_WAIT       = 2'd1,
    REG_RESET_TIMEOUT = 2'd2,
    REG_OFF_PRESS     = 2'd3
  } reg_idx_t;

  localparam count_t OnPressReset      = 16'd100;
  localparam count_t OnWaitReset       = 16'd100;
  localparam count_t ResetTimeoutReset = 16'd5000;
  localparam count_t OffPressReset     = 16'd300;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESS   = 3'd1,
    PH_ONWAIT  = 3'd2,
    PH_RSTHIGH = 3'd3,
    PH_RELEASE = 3'd4,
    PH_RUN     = 3'd5,
    PH_RELIDLE = 3'd6
  } phase_t;

  typedef struct packed {
    count_t on_press_ticks;
    count_t on_wait_ticks;
    count_t reset_timeout_ticks;
    count_t off_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic wake_level;
    logic host_reset_level;
    logic force_on;
    logic carrier_on_request;
  } item_t;

  typedef struct packed {
    logic   power_enable_n;
    logic   board_power;
    logic   carrier_power;
    logic   reset_check;
    phase_t phase;
  } result_t;

  // A press count register of zero behaves as one.
  function automatic count_t at_least_one(input count_t v);
    count_t r;
    r = (v == '0) ? count_t'(1) : v;
    return r;
  endfunction

endpackage

// ===== rtl/core/bps_item_if.sv =====
// ----------------------------------------------------------------------------
// bps_item_if
// Input channel: one sampled tick of the button and host reset pins.
// ----------------------------------------------------------------------------
interface bps_item_if;
  logic valid;
  logic ready;
  logic wake_level;
  logic host_reset_level;
  logic force_on;
  logic carrier_on_request;

  modport source (
    output valid, wake_level, host_reset_level, force_on, carrier_on_request,
    input  ready
  );
  modport sink (
    input  valid, wake_level, host_reset_level, force_on, carrier_on_request,
    output ready
  );
endinterface

// ===== rtl/core/bps_result_if.sv =====
// ----------------------------------------------------------------------------
// bps_result_if
// Output channel: enable levels and phase after one tick.
// ----------------------------------------------------------------------------
interface bps_result_if;
  logic       valid;
  logic       ready;
  logic       power_enable_n;
  logic       board_power;
  logic       carrier_power;
  logic       reset_check;
  logic [2:0] phase;

  modport source (
    output valid, power_enable_n, board_power, carrier_power, reset_check, phase,
    input  ready
  );
  modport sink (
    input  valid, power_enable_n, board_power, carrier_power, reset_check, phase,
    output ready
  );
endinterface

// ===== rtl/core/bps_regs.sv =====
// ----------------------------------------------------------------------------
// bps_regs
// APB-style register file holding the four tick counts.
// ----------------------------------------------------------------------------
module bps_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::AddrWidth-1:0]  paddr,
  input  logic [bps_pkg::DataWidth-1:0]  pwdata,
  output logic [bps_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output bps_pkg::cfg_t                  cfg
);

  bps_pkg::reg_idx_t idx;
  logic              wr_en;
  bps_pkg::count_t   wr_val;
  bps_pkg::count_t   rd_val;

  assign idx    = bps_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = pwdata[bps_pkg::CountWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_press_ticks      <= bps_pkg::OnPressReset;
      cfg.on_wait_ticks       <= bps_pkg::OnWaitReset;
      cfg.reset_timeout_ticks <= bps_pkg::ResetTimeoutReset;
      cfg.off_press_ticks     <= bps_pkg::OffPressReset;
    end else if (wr_en) begin
      case (idx)
        bps_pkg::REG_ON_PRESS:      cfg.on_press_ticks      <= wr_val;
        bps_pkg::REG_ON_WAIT:       cfg.on_wait_ticks       <= wr_val;
        bps_pkg::REG_RESET_TIMEOUT: cfg.reset_timeout_ticks <= wr_val;
        bps_pkg::REG_OFF_PRESS:     cfg.off_press_ticks     <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bps_pkg::REG_ON_PRESS:      rd_val = cfg.on_press_ticks;
      bps_pkg::REG_ON_WAIT:       rd_val = cfg.on_wait_ticks;
      bps_pkg::REG_RESET_TIMEOUT: rd_val = cfg.reset_timeout_ticks;
      bps_pkg::REG_OFF_PRESS:     rd_val = cfg.off_press_ticks;
      default:                    rd_val = '0;
    endcase
  end

  assign prdata = {{(bps_pkg::DataWidth-bps_pkg::CountWidth){1'b0}}, rd_val};

endmodule

// ===== rtl/core/bps_seq.sv =====
// ----------------------------------------------------------------------------
// bps_seq
// Phase state machine with wait and press counters, advanced one tick per step.
// ----------------------------------------------------------------------------
module bps_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  bps_pkg::item_t   item,
  input  bps_pkg::cfg_t    cfg,
  output bps_pkg::result_t result_next
);

  bps_pkg::phase_t phase, phase_next;
  bps_pkg::count_t wait_count, wait_count_next;
  bps_pkg::count_t press_count, press_count_next;
  logic            enable_pin, enable_pin_next;
  logic            board_on, board_on_next;
  logic            carrier_on, carrier_on_next;
  logic            check_flag, check_flag_next;
  logic            pressed;
  logic            reset_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bps_pkg::PH_IDLE;
      wait_count  <= '0;
      press_count <= '0;
      enable_pin  <= 1'b1;
      board_on    <= 1'b0;
      carrier_on  <= 1'b0;
      check_flag  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      press_count <= press_count_next;
      enable_pin  <= enable_pin_next;
      board_on    <= board_on_next;
      carrier_on  <= carrier_on_next;
      check_flag  <= check_flag_next;
    end
  end

  assign pressed   = !item.wake_level;
  assign reset_low = !item.host_reset_level;

  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    press_count_next = press_count;
    enable_pin_next  = enable_pin;
    board_on_next    = board_on;
    check_flag_next  = check_flag;
    // The carrier request is applied before the phase logic, which may clear it.
    carrier_on_next  = carrier_on | item.carrier_on_request;

    if (item.force_on) begin
      wait_count_next = cfg.on_wait_ticks;
      phase_next      = bps_pkg::PH_ONWAIT;
      board_on_next   = 1'b1;
    end else begin
      case (phase)
        bps_pkg::PH_IDLE: begin
          phase_next       = bps_pkg::PH_PRESS;
          enable_pin_next  = 1'b1;
          wait_count_next  = cfg.on_wait_ticks;
          press_count_next = bps_pkg::at_least_one(cfg.on_press_ticks);
        end
        bps_pkg::PH_PRESS: begin
          if (pressed) begin
            if (press_count != '0) begin
              press_count_next = press_count - 1'b1;
              if (press_count == bps_pkg::count_t'(1)) begin
                wait_count_next = cfg.on_wait_ticks;
                phase_next      = bps_pkg::PH_ONWAIT;
                board_on_next   = 1'b1;
              end
            end
          end else begin
            wait_count_next  = cfg.on_wait_ticks;
            press_count_next = bps_pkg::at_least_one(cfg.on_press_ticks);
          end
        end
        bps_pkg::PH_ONWAIT: begin
          if (wait_count != '0) begin
            wait_count_next = wait_count - 1'b1;
          end else begin
            enable_pin_next = 1'b0;
            check_flag_next = 1'b1;
            phase_next      = bps_pkg::PH_RSTHIGH;
            wait_count_next = cfg.reset_timeout_ticks;
          end
        end
        bps_pkg::PH_RSTHIGH: begin
          if (reset_low) begin
            if (wait_count != '0) begin
              wait_count_next = wait_count - 1'b1;
            end else begin
              // Timeout: carrier power and the check flag stay as they are.
              enable_pin_next = 1'b1;
              board_on_next   = 1'b0;
              phase_next      = bps_pkg::PH_RELIDLE;
            end
          end else begin
            phase_next = bps_pkg::PH_RELEASE;
          end
        end
        bps_pkg::PH_RELEASE: begin
          if (!pressed) begin
            press_count_next = bps_pkg::at_least_one(cfg.off_press_ticks);
            phase_next       = bps_pkg::PH_RUN;
          end
        end
        bps_pkg::PH_RUN: begin
          if (pressed) begin
            if (press_count <= bps_pkg::count_t'(1)) begin
              press_count_next = '0;
              check_flag_next  = 1'b0;
              enable_pin_next  = 1'b1;
              carrier_on_next  = 1'b0;
              board_on_next    = 1'b0;
              phase_next       = bps_pkg::PH_RELIDLE;
            end else begin
              press_count_next = press_count - 1'b1;
            end
          end else begin
            press_count_next = bps_pkg::at_least_one(cfg.off_press_ticks);
          end
          // A low host reset overrides the press outcome and drops to idle.
          if (reset_low) begin
            check_flag_next = 1'b0;
            carrier_on_next = 1'b0;
            board_on_next   = 1'b0;
            phase_next      = bps_pkg::PH_IDLE;
          end
        end
        bps_pkg::PH_RELIDLE: begin
          if (!pressed) begin
            phase_next = bps_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = bps_pkg::PH_IDLE;
        end
      endcase
    end
  end

  assign result_next.power_enable_n = enable_pin_next;
  assign result_next.board_power    = board_on_next;
  assign result_next.carrier_power  = carrier_on_next;
  assign result_next.reset_check    = check_flag_next;
  assign result_next.phase          = phase_next;

endmodule

// ===== rtl/core/button_power_sequencer.sv =====
// ----------------------------------------------------------------------------
// button_power_sequencer
// Wake-button power sequencer with input register and output register.
// ----------------------------------------------------------------------------
// Usage: each transfer on the item channel is one sampled tick of the wake
// button, host reset pin, forced power-on and carrier request. For every tick
// one transfer leaves on the result channel with the enable levels and the
// phase as they stand after that tick.
// An accepted tick enters the input register and moves into the result register
// once that register is free; result.valid is high from then on. Throughput is
// one tick per cycle while the receiver does not stall; the phase logic and
// the 16-bit counters settle within the single stage between the two registers.
// The count registers sit on the APB-style port and should only be written
// while no tick is in flight.
// Reset clears the phase to idle, both counters to zero, power enable high
// and all supplies off, and loads the count registers with their defaults.
// When the receiver stalls, the result register holds its transfer and the
// input register takes one more tick; after that item.ready goes low.
// ----------------------------------------------------------------------------
module button_power_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  bps_item_if.sink                      item,
  bps_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bps_pkg::AddrWidth-1:0] paddr,
  input  logic [bps_pkg::DataWidth-1:0] pwdata,
  output logic [bps_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  bps_pkg::cfg_t    cfg;
  bps_pkg::item_t   in_data;
  logic             in_valid;
  bps_pkg::result_t res_next;
  bps_pkg::result_t out_data;
  logic             out_valid;
  logic             step;
  logic             item_take;

  bps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The sequencer advances whenever the held tick can move into a free
  // result register.
  assign step       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || step;
  assign item_take  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_take) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      in_data.wake_level         <= item.wake_level;
      in_data.host_reset_level   <= item.host_reset_level;
      in_data.force_on           <= item.force_on;
      in_data.carrier_on_request <= item.carrier_on_request;
    end
  end

  bps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_data),
    .cfg         (cfg),
    .result_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.power_enable_n = out_data.power_enable_n;
  assign result.board_power    = out_data.board_power;
  assign result.carrier_power  = out_data.carrier_power;
  assign result.reset_check    = out_data.reset_check;
  assign result.phase          = out_data.phase;

endmodule

// ===== tb/bps_sequence_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_sequence_checker
// Watches the tick and level channels and the register port of the button
// power sequencer. It keeps its own copy of the sequencer state and of the
// count registers, predicts the levels after every accepted tick and compares
// each level transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bps_sequence_checker (
  input  logic                          clk,
  input  logic                          rst,
  bps_item_if                           item,
  bps_result_if                         result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bps_pkg::AddrWidth-1:0] paddr,
  input  logic [bps_pkg::DataWidth-1:0] pwdata,
  input  logic [bps_pkg::DataWidth-1:0] prdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);
  import bps_pkg::*;

  count_t  regs [4];
  phase_t  phase_q;
  count_t  wait_left;
  count_t  press_left;
  logic    enable_n;
  logic    board_on;
  logic    carrier_on;
  logic    check_on;
  result_t expected_levels [$];
  result_t want;
  item_t   tick;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic count_t nonzero(input count_t v);
    return (v == '0) ? count_t'(1) : v;
  endfunction

  // Applies one tick to the local copy of the state and returns the levels
  // that the block shows after it.
  function automatic result_t advance_sequencer(input item_t t);
    logic    pressed;
    logic    reset_low;
    result_t r;
    pressed   = !t.wake_level;
    reset_low = !t.host_reset_level;
    if (t.carrier_on_request) carrier_on = 1'b1;
    if (t.force_on) begin
      wait_left = regs[REG_ON_WAIT];
      phase_q   = PH_ONWAIT;
      board_on  = 1'b1;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_q    = PH_PRESS;
          enable_n   = 1'b1;
          wait_left  = regs[REG_ON_WAIT];
          press_left = nonzero(regs[REG_ON_PRESS]);
        end
        PH_PRESS: begin
          if (pressed) begin
            if (press_left != '0) begin
              press_left = press_left - 1'b1;
              if (press_left == '0) begin
                wait_left = regs[REG_ON_WAIT];
                phase_q   = PH_ONWAIT;
                board_on  = 1'b1;
              end
            end
          end else begin
            wait_left  = regs[REG_ON_WAIT];
            press_left = nonzero(regs[REG_ON_PRESS]);
          end
        end
        PH_ONWAIT: begin
          if (wait_left != '0) begin
            wait_left = wait_left - 1'b1;
          end else begin
            enable_n  = 1'b0;
            check_on  = 1'b1;
            phase_q   = PH_RSTHIGH;
            wait_left = regs[REG_RESET_TIMEOUT];
          end
        end
        PH_RSTHIGH: begin
          if (reset_low) begin
            if (wait_left != '0) begin
              wait_left = wait_left - 1'b1;
            end else begin
              // Host reset never came up: drop power but keep the carrier.
              enable_n = 1'b1;
              board_on = 1'b0;
              phase_q  = PH_RELIDLE;
            end
          end else begin
            phase_q = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (!pressed) begin
            press_left = nonzero(regs[REG_OFF_PRESS]);
            phase_q    = PH_RUN;
          end
        end
        PH_RUN: begin
          if (pressed) begin
            if (press_left <= count_t'(1)) begin
              press_left = '0;
              check_on   = 1'b0;
              enable_n   = 1'b1;
              carrier_on = 1'b0;
              board_on   = 1'b0;
              phase_q    = PH_RELIDLE;
            end else begin
              press_left = press_left - 1'b1;
            end
          end else begin
            press_left = nonzero(regs[REG_OFF_PRESS]);
          end
          // A low host reset overrides a shutdown press in the same tick.
          if (reset_low) begin
            check_on   = 1'b0;
            carrier_on = 1'b0;
            board_on   = 1'b0;
            phase_q    = PH_IDLE;
          end
        end
        PH_RELIDLE: begin
          if (!pressed) phase_q = PH_IDLE;
        end
        default: phase_q = PH_IDLE;
      endcase
    end
    r.power_enable_n = enable_n;
    r.board_power    = board_on;
    r.carrier_power  = carrier_on;
    r.reset_check    = check_on;
    r.phase          = phase_q;
    return r;
  endfunction

  task automatic compare_levels(input result_t exp_lv);
    if (result.power_enable_n !== exp_lv.power_enable_n)
      report_mismatch($sformatf("power_enable_n %b, expected %b",
                                result.power_enable_n, exp_lv.power_enable_n));
    if (result.board_power !== exp_lv.board_power)
      report_mismatch($sformatf("board_power %b, expected %b",
                                result.board_power, exp_lv.board_power));
    if (result.carrier_power !== exp_lv.carrier_power)
      report_mismatch($sformatf("carrier_power %b, expected %b",
                                result.carrier_power, exp_lv.carrier_power));
    if (result.reset_check !== exp_lv.reset_check)
      report_mismatch($sformatf("reset_check %b, expected %b",
                                result.reset_check, exp_lv.reset_check));
    if (result.phase !== exp_lv.phase)
      report_mismatch($sformatf("phase %0d, expected %0d", result.phase, exp_lv.phase));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs[REG_ON_PRESS]      = OnPressReset;
      regs[REG_ON_WAIT]       = OnWaitReset;
      regs[REG_RESET_TIMEOUT] = ResetTimeoutReset;
      regs[REG_OFF_PRESS]     = OffPressReset;
      phase_q    = PH_IDLE;
      wait_left  = '0;
      press_left = '0;
      enable_n   = 1'b1;
      board_on   = 1'b0;
      carrier_on = 1'b0;
      check_on   = 1'b0;
      expected_levels.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          regs[paddr[3:2]] = pwdata[CountWidth-1:0];
        end else if (prdata !== DataWidth'(regs[paddr[3:2]])) begin
          report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                    paddr[3:2], prdata, regs[paddr[3:2]]));
        end
      end
      if (result.valid && result.ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("level transfer with no tick outstanding");
        end else begin
          want = expected_levels.pop_front();
          compare_levels(want);
        end
      end
      if (item.valid && item.ready) begin
        tick.wake_level         = item.wake_level;
        tick.host_reset_level   = item.host_reset_level;
        tick.force_on           = item.force_on;
        tick.carrier_on_request = item.carrier_on_request;
        expected_levels.push_back(advance_sequencer(tick));
      end
    end
    pending = expected_levels.size();
  end

endmodule

// ===== tb/button_power_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_power_sequencer_test
// Drives ticks into the button power sequencer: a short directed walk through
// the corner cases, then random power-on and shutdown sessions mixed with
// noise under several register settings and back-pressure patterns. The
// checker beside the block predicts and compares every level transfer.
// ----------------------------------------------------------------------------
module button_power_sequencer_test;
  import bps_pkg::*;

  localparam int CycleLimit = 200000;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending;
  int                   cycle_count;
  int                   sent;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  count_t               cfg_now [4];

  bps_item_if   ticks ();
  bps_result_if levels ();

  button_power_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .item    (ticks),
    .result  (levels),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bps_sequence_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item       (ticks),
    .result     (levels),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver stalls, redrawn every cycle.
  initial begin
    levels.ready = 1'b0;
    forever begin
      @(negedge clk);
      levels.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic coin(input int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic wake, input logic host_rst, input logic force_req,
                           input logic carrier_req);
    while (coin(tx_idle_pct)) begin
      ticks.valid = 1'b0;
      @(negedge clk);
    end
    ticks.valid              = 1'b1;
    ticks.wake_level         = wake;
    ticks.host_reset_level   = host_rst;
    ticks.force_on           = force_req;
    ticks.carrier_on_request = carrier_req;
    do @(posedge clk); while (ticks.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input count_t value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wr ? DataWidth'(value) : '0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers change only once every tick in flight has produced its levels.
  task automatic set_regs(input count_t on_press, input count_t on_wait,
                          input count_t timeout, input count_t off_press);
    int i;
    ticks.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_now[REG_ON_PRESS]      = on_press;
    cfg_now[REG_ON_WAIT]       = on_wait;
    cfg_now[REG_RESET_TIMEOUT] = timeout;
    cfg_now[REG_OFF_PRESS]     = off_press;
    for (i = 0; i < 4; i++) apb_access(1'b1, reg_idx_t'(i), cfg_now[i]);
    for (i = 0; i < 4; i++) apb_access(1'b0, reg_idx_t'(i), '0);
  endtask

  function automatic count_t pick_count();
    case ($urandom_range(0, 11))
      0:       return 16'hFFFF;
      1:       return '0;
      default: return count_t'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic counts_short();
    return cfg_now[REG_ON_PRESS] <= 16 && cfg_now[REG_ON_WAIT] <= 16 &&
           cfg_now[REG_RESET_TIMEOUT] <= 16 && cfg_now[REG_OFF_PRESS] <= 16;
  endfunction

  // One session from idle: long press to power on, the on wait, then host reset
  // and a shutdown press or a low host reset, or the timeout and a release.
  task automatic power_cycle();
    int press_need;
    int off_need;
    press_need = (cfg_now[REG_ON_PRESS] == 0) ? 1 : cfg_now[REG_ON_PRESS];
    off_need   = (cfg_now[REG_OFF_PRESS] == 0) ? 1 : cfg_now[REG_OFF_PRESS];
    send_tick(1'b1, coin(50), 1'b0, coin(10));
    if (coin(15)) begin
      repeat ($urandom_range(1, press_need)) send_tick(1'b0, 1'b1, 1'b0, coin(10));
      send_tick(1'b1, 1'b1, 1'b0, coin(10));
    end
    repeat (press_need) send_tick(1'b0, coin(50), 1'b0, coin(10));
    repeat (cfg_now[REG_ON_WAIT] + 1)
      send_tick(coin(50), 1'b0, 1'b0, coin(10));
    if (coin(20)) begin
      repeat (cfg_now[REG_RESET_TIMEOUT] + 1)
        send_tick(coin(50), 1'b0, 1'b0, coin(10));
      send_tick(1'b0, coin(50), 1'b0, 1'b0);
      send_tick(1'b1, coin(50), 1'b0, 1'b0);
    end else begin
      repeat ($urandom_range(0, cfg_now[REG_RESET_TIMEOUT]))
        send_tick(coin(50), 1'b0, 1'b0, coin(10));
      send_tick(1'b0, 1'b1, 1'b0, coin(10));
      repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b1, 1'b0, coin(10));
      send_tick(1'b1, 1'b1, 1'b0, coin(10));
      repeat ($urandom_range(1, 6)) send_tick(!coin(30), 1'b1, 1'b0, coin(10));
      if (coin(50)) begin
        repeat (off_need) send_tick(1'b0, 1'b1, 1'b0, coin(10));
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
      end else begin
        send_tick(coin(50), 1'b0, 1'b0, coin(10));
      end
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 15))
      send_tick(coin(50), coin(50), coin(6), coin(12));
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct, input int count);
    int phase_end;
    int block_end;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_end   = sent + count;
    while (sent < phase_end) begin
      set_regs(pick_count(), pick_count(), pick_count(), pick_count());
      block_end = sent + 100;
      while (sent < block_end) begin
        if (counts_short() && coin(85)) power_cycle();
        else noise_burst();
      end
    end
  endtask

  initial begin
    rst                      = 1'b1;
    sent                     = 0;
    tx_idle_pct              = 35;
    rx_idle_pct              = 77;
    ticks.valid              = 1'b0;
    ticks.wake_level         = 1'b1;
    ticks.host_reset_level   = 1'b1;
    ticks.force_on           = 1'b0;
    ticks.carrier_on_request = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    cfg_now[REG_ON_PRESS]      = OnPressReset;
    cfg_now[REG_ON_WAIT]       = OnWaitReset;
    cfg_now[REG_RESET_TIMEOUT] = ResetTimeoutReset;
    cfg_now[REG_OFF_PRESS]     = OffPressReset;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed walk with the default counts, then all counts zero.
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    set_regs('0, '0, '0, '0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    // Host reset stays low with no timeout left.
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    // Shutdown press and low host reset in the same tick.
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);

    random_phase(35, 77, 510);
    random_phase(77, 35, 510);
    random_phase(0, 0, 510);

    ticks.valid = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bps_pkg.sv
rtl/core/bps_item_if.sv
rtl/core/bps_result_if.sv
rtl/core/bps_regs.sv
rtl/core/bps_seq.sv
rtl/core/button_power_sequencer.sv
tb/bps_sequence_checker.sv
tb/button_power_sequencer_test.sv
